[rtl/hsv_fade_sequencer_defines.svh]
// Assertion macros for the fade sequencer RTL.
`ifndef HSV_FADE_SEQUENCER_DEFINES_SVH
`define HSV_FADE_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS
// Check cons in the same cycle as ante.
`define HFS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hfs: assertion failed");
// Check cons in the cycle after ante.
`define HFS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hfs: assertion failed");
`else
`define HFS_ASSERT_NOW(label, ante, cons)
`define HFS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[rtl/hfs_pkg.sv]
package hfs_pkg;

    // Slot table geometry
    localparam int MAX_SLOTS = 16;
    localparam int SLOT_AW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

    // Field widths
    localparam int CH_W  = 16;
    localparam int DUR_W = 15;
    localparam int CMD_W = 3;

    // Quotient bits produced by the serial divider
    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [CH_W-1:0] TICK_PERIOD_RESET = 16'd312;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TICK       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_APPEND     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PLAY_SLOT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PLAY_PROG  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SET_COLOUR = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SET_WHITE  = 3'd6;

    typedef struct packed {
        logic        [CH_W-1:0]  h;
        logic        [CH_W-1:0]  s;
        logic        [CH_W-1:0]  v;
        logic signed [CH_W-1:0]  dh;
        logic signed [CH_W-1:0]  ds;
        logic signed [CH_W-1:0]  dv;
        logic        [DUR_W-1:0] dur;
    } slot_t;

    localparam slot_t SLOT_RESET = '{h: '0, s: '0, v: '0, dh: '0, ds: '0, dv: '0,
                                     dur: 15'd10};

    // Access request to the slot memory
    typedef struct packed {
        logic               rd_en;
        logic [SLOT_AW-1:0] rd_addr;
        logic               wr_en;
        logic [SLOT_AW-1:0] wr_addr;
    } ram_req_t;

endpackage

[rtl/hfs_slot_ram.sv]
module hfs_slot_ram
    import hfs_pkg::*;
(
    input  logic     clk,
    input  ram_req_t req,
    input  slot_t    wr_data,
    output slot_t    rd_data
);

    slot_t mem [MAX_SLOTS];

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

[rtl/hfs_interp.sv]
module hfs_interp
    import hfs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic        [CH_W-1:0]  start_val,
    input  logic signed [CH_W-1:0]  delta,
    input  logic        [CH_W-1:0]  step,
    input  logic        [DUR_W-1:0] dur,
    output logic                    done,
    output logic        [CH_W-1:0]  result
);

    typedef enum logic [3:0] {
        I_IDLE = 4'b0001,
        I_PREP = 4'b0010,
        I_DIV  = 4'b0100,
        I_FIN  = 4'b1000
    } interp_state_t;

    interp_state_t          state_reg, state_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic signed [32:0]     prod_reg, prod_next;
    logic                   neg_reg, neg_next;
    logic [DUR_W-1:0]       rem_reg, rem_next;
    logic [CH_W-1:0]        low_reg, low_next;

    logic signed [32:0]     mag;
    logic [CH_W:0]          trial;
    logic                   fits;
    logic [CH_W-1:0]        adj;

    // Magnitude of the product; it stays below 2^31
    assign mag = prod_reg[32] ? -prod_reg : prod_reg;

    // One restoring division step: shift in the next dividend bit, try a subtract
    assign trial = {1'b0, rem_reg, low_reg[CH_W-1]};
    assign fits  = trial >= {2'b00, dur};

    // Apply the sign of the product and add the start value
    assign adj    = neg_reg ? (CH_W'(0) - low_reg) : low_reg;
    assign result = (dur == '0) ? start_val : (start_val + adj);
    assign done   = (state_reg == I_FIN);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        prod_next  = prod_reg;
        neg_next   = neg_reg;
        rem_next   = rem_reg;
        low_next   = low_reg;
        case (state_reg)
            I_IDLE:
            begin
                if (start)
                begin
                    prod_next  = delta * $signed({1'b0, step});
                    state_next = I_PREP;
                end
            end
            I_PREP:
            begin
                // Upper bits start below dur since step < dur
                neg_next   = prod_reg[32];
                rem_next   = mag[30:16];
                low_next   = mag[15:0];
                cnt_next   = '0;
                state_next = I_DIV;
            end
            I_DIV:
            begin
                rem_next = fits ? DUR_W'(trial - {2'b00, dur}) : trial[DUR_W-1:0];
                low_next = {low_reg[CH_W-2:0], fits};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = I_FIN;
                end
            end
            I_FIN:
            begin
                state_next = I_IDLE;
            end
            default:
            begin
                state_next = I_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= I_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        neg_reg  <= neg_next;
        rem_reg  <= rem_next;
        low_reg  <= low_next;
    end

endmodule

[rtl/hsv_fade_sequencer.sv]
// HSV fade sequencer.
// Input channel (in_valid/in_ready) takes one command item with its slot fields;
// output channel (out_valid/out_ready) gives one colour item per command that
// produces one. The cfg channel (cfg_valid/cfg_ready, cfg_data) writes the
// prescaler period and is always ready; write it only while the block is idle.
// Flow: clear and append stay in idle; play slot, set colour and set white go
// through the emit state to the output register; play program first does one
// slot memory read. A tick that fires an animation step runs the
// three channel interpolators: one multiply, a 16-step serial divider and a final
// add, then the emit state loads the output register, with a memory read first when
// a program moves to its next slot. Items are handled one at a time.
// Reset: output empty, not running, slot count zero, period 312, active slot
// black with duration ten. The slot memory is not cleared; its entries are
// valid once appended.
// A stalled receiver holds the result in the output register; the next item is
// still accepted, and a new result waits until the register is taken.
`include "hsv_fade_sequencer_defines.svh"

module hsv_fade_sequencer
    import hfs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic        [CMD_W-1:0] command,
    input  logic        [CH_W-1:0]  hue,
    input  logic        [CH_W-1:0]  saturation,
    input  logic        [CH_W-1:0]  brightness,
    input  logic signed [CH_W-1:0]  hue_delta,
    input  logic signed [CH_W-1:0]  saturation_delta,
    input  logic signed [CH_W-1:0]  brightness_delta,
    input  logic        [DUR_W-1:0] duration,

    output logic                    out_valid,
    input  logic                    out_ready,
    output logic        [CH_W-1:0]  out_hue,
    output logic        [CH_W-1:0]  out_saturation,
    output logic        [CH_W-1:0]  out_value,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic        [CH_W-1:0]  cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_START = 5'b00100,
        S_CALC  = 5'b01000,
        S_EMIT  = 5'b10000
    } seq_state_t;

    seq_state_t         state_reg, state_next;
    logic [CH_W-1:0]    tick_period_reg, tick_period_next;
    logic [CNT_W-1:0]   slot_total_reg, slot_total_next;
    logic [SLOT_AW-1:0] play_index_reg, play_index_next;
    slot_t              active_reg, active_next;
    logic [CH_W-1:0]    step_count_reg, step_count_next;
    logic [CH_W-1:0]    prescale_reg, prescale_next;
    logic               running_reg, running_next;
    logic               program_mode_reg, program_mode_next;
    logic               prog_start_reg, prog_start_next;
    logic               out_valid_reg, out_valid_next;

    logic [CH_W-1:0]    pend_h_reg, pend_h_next;
    logic [CH_W-1:0]    pend_s_reg, pend_s_next;
    logic [CH_W-1:0]    pend_v_reg, pend_v_next;
    logic [CH_W-1:0]    out_h_reg, out_h_next;
    logic [CH_W-1:0]    out_s_reg, out_s_next;
    logic [CH_W-1:0]    out_v_reg, out_v_next;

    slot_t              in_slot;
    slot_t              rd_data;
    ram_req_t           ram_req;
    logic               fire;
    logic               step_wrap;
    logic [CNT_W-1:0]   nxt_idx;
    logic               calc_start;
    logic               done_h, done_s, done_v;
    logic [CH_W-1:0]    res_h, res_s, res_v;

    assign in_slot = '{h: hue, s: saturation, v: brightness, dh: hue_delta,
                       ds: saturation_delta, dv: brightness_delta, dur: duration};

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_hue        = out_h_reg;
    assign out_saturation = out_s_reg;
    assign out_value      = out_v_reg;

    assign fire       = (prescale_reg == tick_period_reg);
    assign step_wrap  = (step_count_reg >= {1'b0, active_reg.dur});
    assign nxt_idx    = CNT_W'(play_index_reg) + CNT_W'(1);
    assign calc_start = (state_reg == S_START);

    hfs_slot_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .wr_data (in_slot),
        .rd_data (rd_data)
    );

    hfs_interp u_interp_h (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (calc_start),
        .start_val (active_reg.h),
        .delta     (active_reg.dh),
        .step      (step_count_reg),
        .dur       (active_reg.dur),
        .done      (done_h),
        .result    (res_h)
    );

    hfs_interp u_interp_s (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (calc_start),
        .start_val (active_reg.s),
        .delta     (active_reg.ds),
        .step      (step_count_reg),
        .dur       (active_reg.dur),
        .done      (done_s),
        .result    (res_s)
    );

    hfs_interp u_interp_v (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (calc_start),
        .start_val (active_reg.v),
        .delta     (active_reg.dv),
        .step      (step_count_reg),
        .dur       (active_reg.dur),
        .done      (done_v),
        .result    (res_v)
    );

    always_comb
    begin
        state_next        = state_reg;
        tick_period_next  = tick_period_reg;
        slot_total_next   = slot_total_reg;
        play_index_next   = play_index_reg;
        active_next       = active_reg;
        step_count_next   = step_count_reg;
        prescale_next     = prescale_reg;
        running_next      = running_reg;
        program_mode_next = program_mode_reg;
        prog_start_next   = prog_start_reg;
        out_valid_next    = out_valid_reg;
        pend_h_next       = pend_h_reg;
        pend_s_next       = pend_s_reg;
        pend_v_next       = pend_v_reg;
        out_h_next        = out_h_reg;
        out_s_next        = out_s_reg;
        out_v_next        = out_v_reg;
        ram_req           = '0;

        // Take a period write
        if (cfg_valid)
        begin
            tick_period_next = cfg_data;
        end

        // Drop the output item once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (command)
                        CMD_TICK:
                        begin
                            prescale_next = (fire ? '0 : prescale_reg) + 1'b1;
                            if (fire && running_reg)
                            begin
                                state_next = S_START;
                                if (step_wrap)
                                begin
                                    step_count_next = '0;
                                    if (program_mode_reg)
                                    begin
                                        // Advance to the next slot and fetch it
                                        play_index_next = (nxt_idx >= slot_total_reg) ?
                                                          '0 : nxt_idx[SLOT_AW-1:0];
                                        ram_req.rd_en   = 1'b1;
                                        ram_req.rd_addr = play_index_next;
                                        prog_start_next = 1'b0;
                                        state_next      = S_READ;
                                    end
                                end
                            end
                        end
                        CMD_CLEAR:
                        begin
                            slot_total_next = '0;
                        end
                        CMD_APPEND:
                        begin
                            if (slot_total_reg < CNT_W'(MAX_SLOTS))
                            begin
                                ram_req.wr_en   = 1'b1;
                                ram_req.wr_addr = slot_total_reg[SLOT_AW-1:0];
                                slot_total_next = slot_total_reg + 1'b1;
                            end
                        end
                        CMD_PLAY_SLOT:
                        begin
                            program_mode_next = 1'b0;
                            active_next       = in_slot;
                            running_next      = 1'b1;
                            prescale_next     = '0;
                            step_count_next   = CH_W'(1);
                            pend_h_next       = hue;
                            pend_s_next       = saturation;
                            pend_v_next       = brightness;
                            state_next        = S_EMIT;
                        end
                        CMD_PLAY_PROG:
                        begin
                            program_mode_next = 1'b1;
                            play_index_next   = '0;
                            running_next      = 1'b1;
                            prescale_next     = '0;
                            step_count_next   = CH_W'(1);
                            ram_req.rd_en     = 1'b1;
                            ram_req.rd_addr   = '0;
                            prog_start_next   = 1'b1;
                            state_next        = S_READ;
                        end
                        CMD_SET_COLOUR:
                        begin
                            running_next = 1'b0;
                            pend_h_next  = hue;
                            pend_s_next  = saturation;
                            pend_v_next  = brightness;
                            state_next   = S_EMIT;
                        end
                        CMD_SET_WHITE:
                        begin
                            running_next = 1'b0;
                            pend_h_next  = '0;
                            pend_s_next  = '0;
                            pend_v_next  = brightness;
                            state_next   = S_EMIT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                // Load the fetched slot; a program start shows its start colour
                active_next = rd_data;
                if (prog_start_reg)
                begin
                    pend_h_next = rd_data.h;
                    pend_s_next = rd_data.s;
                    pend_v_next = rd_data.v;
                    state_next  = S_EMIT;
                end
                else
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                state_next = S_CALC;
            end
            S_CALC:
            begin
                if (done_h)
                begin
                    pend_h_next     = res_h;
                    pend_s_next     = res_s;
                    pend_v_next     = res_v;
                    step_count_next = step_count_reg + 1'b1;
                    state_next      = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_h_next     = pend_h_reg;
                    out_s_next     = pend_s_reg;
                    out_v_next     = pend_v_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            tick_period_reg  <= TICK_PERIOD_RESET;
            slot_total_reg   <= '0;
            play_index_reg   <= '0;
            active_reg       <= SLOT_RESET;
            step_count_reg   <= '0;
            prescale_reg     <= '0;
            running_reg      <= 1'b0;
            program_mode_reg <= 1'b0;
            prog_start_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            tick_period_reg  <= tick_period_next;
            slot_total_reg   <= slot_total_next;
            play_index_reg   <= play_index_next;
            active_reg       <= active_next;
            step_count_reg   <= step_count_next;
            prescale_reg     <= prescale_next;
            running_reg      <= running_next;
            program_mode_reg <= program_mode_next;
            prog_start_reg   <= prog_start_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_h_reg <= pend_h_next;
        pend_s_reg <= pend_s_next;
        pend_v_reg <= pend_v_next;
        out_h_reg  <= out_h_next;
        out_s_reg  <= out_s_next;
        out_v_reg  <= out_v_next;
    end

    // Slot count never passes the table size
    `HFS_ASSERT_NOW(a_total_bound, 1'b1, slot_total_reg <= CNT_W'(MAX_SLOTS))
    // Interpolation only runs while playing
    `HFS_ASSERT_NOW(a_start_running, state_reg == S_START, running_reg)
    // Divider precondition: the step lies inside the slot
    `HFS_ASSERT_NOW(a_step_in_slot, state_reg == S_START && active_reg.dur != '0,
                    step_count_reg < {1'b0, active_reg.dur})
    // The three channel units finish together
    `HFS_ASSERT_NOW(a_lanes_lockstep, state_reg == S_CALC,
                    done_h == done_s && done_s == done_v)
    // A pending result waits while the output item is stalled
    `HFS_ASSERT_NEXT(a_emit_holds, state_reg == S_EMIT && out_valid_reg && !out_ready,
                     state_reg == S_EMIT)

endmodule

[tb/hsv_fade_checker.sv]
module hsv_fade_checker
    import hfs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic        [CMD_W-1:0] command,
    input  logic        [CH_W-1:0]  hue,
    input  logic        [CH_W-1:0]  saturation,
    input  logic        [CH_W-1:0]  brightness,
    input  logic signed [CH_W-1:0]  hue_delta,
    input  logic signed [CH_W-1:0]  saturation_delta,
    input  logic signed [CH_W-1:0]  brightness_delta,
    input  logic        [DUR_W-1:0] duration,

    input  logic                    out_valid,
    input  logic                    out_ready,
    input  logic        [CH_W-1:0]  out_hue,
    input  logic        [CH_W-1:0]  out_saturation,
    input  logic        [CH_W-1:0]  out_value,

    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic        [CH_W-1:0]  cfg_data,

    output int                      failures,
    output int                      outstanding,
    output int                      compared
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CH_W-1:0] h;
        logic [CH_W-1:0] s;
        logic [CH_W-1:0] v;
    } color_t;

    // Shadow of the fader state
    logic [CH_W-1:0]    period_q;
    slot_t              slot_mem [MAX_SLOTS];
    logic [CNT_W-1:0]   slots_q;
    logic [SLOT_AW-1:0] play_ptr;
    slot_t              active;
    logic [CH_W-1:0]    step_q;
    logic [CH_W-1:0]    prescale_q;
    logic               running_q;
    logic               program_q;

    color_t             pending_colors [$];
    color_t             next_color;
    color_t             want;
    slot_t              in_slot;
    logic               has_color;

    // start + delta*step/dur, quotient truncated toward zero, wrapped to 16 bits
    function automatic logic [CH_W-1:0] lerp_channel(input logic [CH_W-1:0] start,
                                                     input logic signed [CH_W-1:0] delta,
                                                     input logic [CH_W-1:0] step,
                                                     input logic [DUR_W-1:0] dur);
        int q;
        if (dur == '0)
            return start;
        q = (int'(delta) * int'(step)) / int'(dur);
        return start + q[CH_W-1:0];
    endfunction

    function automatic color_t fade_color(input slot_t sl, input logic [CH_W-1:0] step);
        color_t c;
        c.h = lerp_channel(sl.h, $signed(sl.dh), step, sl.dur);
        c.s = lerp_channel(sl.s, $signed(sl.ds), step, sl.dur);
        c.v = lerp_channel(sl.v, $signed(sl.dv), step, sl.dur);
        return c;
    endfunction

    // Apply one command to the shadow state; report the colour it emits, if any
    task automatic advance_fader(input logic [CMD_W-1:0] cmd, input slot_t in_sl,
                                 output logic hit, output color_t col);
        logic fire;
        int   nxt;
        hit = 1'b0;
        col = '0;
        case (cmd)
            CMD_TICK:
            begin
                fire = (prescale_q == period_q);
                if (fire)
                    prescale_q = '0;
                prescale_q = prescale_q + 1'b1;
                if (fire && running_q)
                begin
                    // end of slot: restart the step count, move to the next program slot
                    if (step_q >= active.dur)
                    begin
                        step_q = '0;
                        if (program_q)
                        begin
                            nxt = int'(play_ptr) + 1;
                            if (nxt >= int'(slots_q))
                                nxt = 0;
                            play_ptr = nxt[SLOT_AW-1:0];
                            active = slot_mem[play_ptr];
                        end
                    end
                    col = fade_color(active, step_q);
                    step_q = step_q + 1'b1;
                    hit = 1'b1;
                end
            end
            CMD_CLEAR:
                slots_q = '0;
            CMD_APPEND:
            begin
                // drop appends once the table is full
                if (slots_q < MAX_SLOTS)
                begin
                    slot_mem[slots_q[SLOT_AW-1:0]] = in_sl;
                    slots_q = slots_q + 1'b1;
                end
            end
            CMD_PLAY_SLOT, CMD_PLAY_PROG:
            begin
                if (cmd == CMD_PLAY_SLOT)
                begin
                    program_q = 1'b0;
                    active = in_sl;
                end
                else
                begin
                    program_q = 1'b1;
                    play_ptr = '0;
                    active = slot_mem[0];
                end
                running_q = 1'b1;
                prescale_q = '0;
                step_q = 16'd1;
                col = '{h: active.h, s: active.s, v: active.v};
                hit = 1'b1;
            end
            CMD_SET_COLOUR:
            begin
                running_q = 1'b0;
                col = '{h: in_sl.h, s: in_sl.s, v: in_sl.v};
                hit = 1'b1;
            end
            CMD_SET_WHITE:
            begin
                running_q = 1'b0;
                col = '{h: '0, s: '0, v: in_sl.v};
                hit = 1'b1;
            end
            default: ;
        endcase
    endtask

    // Predict on accepted commands, compare accepted colour items
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_q    = TICK_PERIOD_RESET;
            slots_q     = '0;
            play_ptr    = '0;
            active      = SLOT_RESET;
            step_q      = '0;
            prescale_q  = '0;
            running_q   = 1'b0;
            program_q   = 1'b0;
            pending_colors.delete();
            failures    = 0;
            outstanding = 0;
            compared    = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                period_q = cfg_data;

            if (in_valid && in_ready)
            begin
                in_slot = '{h: hue, s: saturation, v: brightness, dh: hue_delta,
                            ds: saturation_delta, dv: brightness_delta, dur: duration};
                advance_fader(command, in_slot, has_color, next_color);
                if (has_color)
                    pending_colors.push_back(next_color);
            end

            if (out_valid && out_ready)
            begin
                if (pending_colors.size() == 0)
                begin
                    $error("unexpected colour item: hue %h saturation %h value %h",
                           out_hue, out_saturation, out_value);
                    failures++;
                end
                else
                begin
                    want = pending_colors.pop_front();
                    compared++;
                    if (out_hue !== want.h)
                    begin
                        $error("out_hue: expected %h, got %h", want.h, out_hue);
                        failures++;
                    end
                    if (out_saturation !== want.s)
                    begin
                        $error("out_saturation: expected %h, got %h", want.s, out_saturation);
                        failures++;
                    end
                    if (out_value !== want.v)
                    begin
                        $error("out_value: expected %h, got %h", want.v, out_value);
                        failures++;
                    end
                end
            end

            outstanding = pending_colors.size();
        end
    end

endmodule

[tb/hsv_fade_sequencer_tb.sv]
module hsv_fade_sequencer_tb;
    import hfs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CMD_W-1:0] CMD_UNUSED  = 3'd7;
    localparam int               RANDOM_ITEMS = 1950;

    logic                    clk = 1'b0;
    logic                    rst_n;

    logic                    in_valid;
    logic                    in_ready;
    logic        [CMD_W-1:0] command;
    logic        [CH_W-1:0]  hue;
    logic        [CH_W-1:0]  saturation;
    logic        [CH_W-1:0]  brightness;
    logic signed [CH_W-1:0]  hue_delta;
    logic signed [CH_W-1:0]  saturation_delta;
    logic signed [CH_W-1:0]  brightness_delta;
    logic        [DUR_W-1:0] duration;

    logic                    out_valid;
    logic                    out_ready;
    logic        [CH_W-1:0]  out_hue;
    logic        [CH_W-1:0]  out_saturation;
    logic        [CH_W-1:0]  out_value;

    logic                    cfg_valid;
    logic                    cfg_ready;
    logic        [CH_W-1:0]  cfg_data;

    int                      failures;
    int                      outstanding;
    int                      compared;

    // Stimulus bookkeeping
    bit                      no_gaps;
    bit                      slot0_written;
    int                      table_fill;
    int                      items_sent;
    int                      ticks_sent;
    int                      appends_sent;
    int                      program_plays;
    int                      phase;
    int                      phase_end;

    hsv_fade_sequencer i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .command          (command),
        .hue              (hue),
        .saturation       (saturation),
        .brightness       (brightness),
        .hue_delta        (hue_delta),
        .saturation_delta (saturation_delta),
        .brightness_delta (brightness_delta),
        .duration         (duration),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_hue          (out_hue),
        .out_saturation   (out_saturation),
        .out_value        (out_value),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data)
    );

    hsv_fade_checker i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .command          (command),
        .hue              (hue),
        .saturation       (saturation),
        .brightness       (brightness),
        .hue_delta        (hue_delta),
        .saturation_delta (saturation_delta),
        .brightness_delta (brightness_delta),
        .duration         (duration),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_hue          (out_hue),
        .out_saturation   (out_saturation),
        .out_value        (out_value),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .failures         (failures),
        .outstanding      (outstanding),
        .compared         (compared)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop for a hung handshake
    initial
    begin
        #6ms;
        $display("timeout: colour items still outstanding: %0d", outstanding);
        $display("end of test: mismatches");
        $finish;
    end

    function automatic slot_t make_slot(input logic [CH_W-1:0] h, input logic [CH_W-1:0] s,
                                        input logic [CH_W-1:0] v, input logic [CH_W-1:0] dh,
                                        input logic [CH_W-1:0] ds, input logic [CH_W-1:0] dv,
                                        input logic [DUR_W-1:0] dur);
        slot_t sl;
        sl.h   = h;
        sl.s   = s;
        sl.v   = v;
        sl.dh  = dh;
        sl.ds  = ds;
        sl.dv  = dv;
        sl.dur = dur;
        return sl;
    endfunction

    // Word biased toward the corners of the range
    function automatic logic [CH_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            default: return CH_W'($urandom);
        endcase
    endfunction

    // Mostly short slots so programs wrap often; a few long ones
    function automatic logic [DUR_W-1:0] pick_duration();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return DUR_W'($urandom_range(0, 8));
        if (r < 92)
            return DUR_W'($urandom_range(9, 60));
        if (r < 96)
            return '1;
        return DUR_W'($urandom);
    endfunction

    function automatic slot_t rand_slot();
        return make_slot(pick_word(), pick_word(), pick_word(), pick_word(), pick_word(),
                         pick_word(), pick_duration());
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    function automatic logic [CH_W-1:0] pick_period(input int ph);
        int r;
        case (ph)
            0:       return '0;
            1:       return '1;
            2:       return TICK_PERIOD_RESET;
            default:
            begin
                r = $urandom_range(0, 9);
                if (r < 7)
                    return CH_W'($urandom_range(1, 3));
                if (r < 9)
                    return CH_W'($urandom_range(4, 12));
                return CH_W'($urandom_range(13, 40));
            end
        endcase
    endfunction

    // Present one item, hold it until accepted, then maybe idle
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input slot_t sl);
        int gap;
        command          = cmd;
        hue              = sl.h;
        saturation       = sl.s;
        brightness       = sl.v;
        hue_delta        = sl.dh;
        saturation_delta = sl.ds;
        brightness_delta = sl.dv;
        duration         = sl.dur;
        in_valid         = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        case (cmd)
            CMD_TICK:
                ticks_sent++;
            CMD_CLEAR:
                table_fill = 0;
            CMD_APPEND:
            begin
                appends_sent++;
                if (table_fill == 0)
                    slot0_written = 1'b1;
                if (table_fill < MAX_SLOTS)
                    table_fill++;
            end
            CMD_PLAY_PROG:
                program_plays++;
            default: ;
        endcase
        if (cmd != CMD_UNUSED)
            items_sent++;
        @(negedge clk);
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Hold off until every predicted colour has arrived and the block has settled
    task automatic wait_idle();
        int guard;
        in_valid = 1'b0;
        guard = 0;
        while (outstanding != 0 && guard < 100000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (64) @(negedge clk);
    endtask

    task automatic write_period(input logic [CH_W-1:0] value);
        cfg_data  = value;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // One random sequence: a program, a single slot, or loose commands
    task automatic run_chunk();
        int               kind;
        int               n;
        logic [CMD_W-1:0] c;
        kind = $urandom_range(0, 9);
        no_gaps = ($urandom_range(0, 3) == 0);
        if (kind < 5)
        begin
            if (!slot0_written || $urandom_range(0, 2) != 0)
                send_cmd(CMD_CLEAR, rand_slot());
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_SLOTS, MAX_SLOTS + 3)
                                             : $urandom_range(1, 4);
            repeat (n) send_cmd(CMD_APPEND, rand_slot());
            send_cmd(CMD_PLAY_PROG, rand_slot());
            repeat ($urandom_range(5, 40)) send_cmd(CMD_TICK, rand_slot());
        end
        else if (kind < 8)
        begin
            send_cmd(CMD_PLAY_SLOT, rand_slot());
            repeat ($urandom_range(5, 40)) send_cmd(CMD_TICK, rand_slot());
        end
        else
        begin
            repeat ($urandom_range(3, 10))
            begin
                c = CMD_W'($urandom_range(0, 7));
                // never start a program on a table slot that was never written
                if (c == CMD_PLAY_PROG && !slot0_written)
                    c = CMD_TICK;
                send_cmd(c, rand_slot());
            end
        end
        if ($urandom_range(0, 19) == 0)
            wait_idle();
    endtask

    // Run chunks until this phase has its share of items
    task automatic n_phase_items(input int ph);
        int stop_at;
        stop_at = items_sent + ((ph < 3) ? 40 : 150);
        while (items_sent < stop_at && items_sent < phase_end)
            run_chunk();
    endtask

    // Output back-pressure: free-flowing stretches, random stalls, some long stalls
    initial
    begin
        int pick;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            pick = $urandom_range(0, 9);
            if (pick < 4)
            begin
                out_ready = 1'b1;
                repeat ($urandom_range(20, 200)) @(negedge clk);
            end
            else if (pick < 8)
            begin
                repeat ($urandom_range(1, 40))
                begin
                    out_ready = ($urandom_range(0, 9) < 7);
                    @(negedge clk);
                end
            end
            else
            begin
                out_ready = 1'b0;
                repeat ((pick == 8) ? $urandom_range(1, 5) : $urandom_range(20, 60))
                    @(negedge clk);
            end
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        command          = CMD_TICK;
        hue              = '0;
        saturation       = '0;
        brightness       = '0;
        hue_delta        = '0;
        saturation_delta = '0;
        brightness_delta = '0;
        duration         = '0;
        cfg_valid        = 1'b0;
        cfg_data         = '0;
        no_gaps          = 1'b0;
        slot0_written    = 1'b0;
        table_fill       = 0;
        items_sent       = 0;
        ticks_sent       = 0;
        appends_sent     = 0;
        program_plays    = 0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Fixed colours and white at the field corners; unused code and idle tick do nothing
        send_cmd(CMD_SET_COLOUR, make_slot(16'hFFFF, 16'h0000, 16'hFFFF, '0, '0, '0, '0));
        send_cmd(CMD_SET_COLOUR, make_slot(16'h0000, 16'hFFFF, 16'h0000, '1, '1, '1, '1));
        send_cmd(CMD_SET_WHITE, make_slot(16'h1234, 16'h5678, 16'hFFFF, '0, '0, '0, '0));
        send_cmd(CMD_SET_WHITE, make_slot(16'hFFFF, 16'hFFFF, 16'h0000, '1, '1, '1, '1));
        send_cmd(CMD_UNUSED, make_slot('1, '1, '1, '1, '1, '1, '1));
        send_cmd(CMD_TICK, rand_slot());

        // Zero duration holds the start colour
        send_cmd(CMD_PLAY_SLOT, make_slot(16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h8000,
                                          16'h0001, 15'd0));
        wait_idle();
        write_period(16'd1);
        repeat (3) send_cmd(CMD_TICK, rand_slot());

        // Tiny negative delta over a maximal slot truncates toward zero
        send_cmd(CMD_PLAY_SLOT, make_slot(16'h0000, 16'hFFFF, 16'h8000, 16'h8000, 16'h7FFF,
                                          16'hFFFF, 15'h7FFF));
        repeat (2) send_cmd(CMD_TICK, rand_slot());

        // Short slot: negative quotient wraps below zero, step count restarts
        send_cmd(CMD_PLAY_SLOT, make_slot(16'h0002, 16'hFFFE, 16'h0000, 16'hFFF9, 16'h0005,
                                          16'h0000, 15'd3));
        repeat (4) send_cmd(CMD_TICK, rand_slot());

        // Two-slot program loops; playing it again restarts at slot zero
        send_cmd(CMD_CLEAR, rand_slot());
        send_cmd(CMD_APPEND, make_slot(16'h1000, 16'h2000, 16'h3000, 16'h0100, 16'hFF00,
                                       16'h0010, 15'd2));
        send_cmd(CMD_APPEND, make_slot(16'hF000, 16'h0000, 16'hFFFF, 16'h7FFF, 16'h7FFF,
                                       16'h8000, 15'd1));
        send_cmd(CMD_PLAY_PROG, rand_slot());
        repeat (4) send_cmd(CMD_TICK, rand_slot());
        send_cmd(CMD_PLAY_PROG, rand_slot());
        send_cmd(CMD_TICK, rand_slot());

        // Random phases, each under its own prescaler period
        phase = 0;
        phase_end = items_sent;
        while (items_sent < phase_end + RANDOM_ITEMS - (phase_end - items_sent) && phase < 1000)
        begin
            if (phase == 0)
                phase_end = items_sent + RANDOM_ITEMS;
            wait_idle();
            write_period(pick_period(phase));
            n_phase_items(phase);
            phase++;
            if (items_sent >= phase_end)
                break;
        end

        wait_idle();
        if (outstanding != 0)
            $error("%0d predicted colour items never arrived", outstanding);
        $display("covered %0d commands: %0d ticks, %0d appends, %0d program plays, %0d periods",
                 items_sent, ticks_sent, appends_sent, program_plays, phase + 1);
        $display("compared %0d colour items against the prediction", compared);
        if (failures == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
